>>> sv/epcm_pkg.sv
// equal-power crossfade mixer: shared types, constants and the gain table
// the gain table is built at elaboration from a fixed-point sine/cosine series
// no dependencies
`default_nettype none

package epcm_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int PHASE_BITS   = 10;
  localparam int CHANNELS     = 2;
  localparam int LEN_BITS     = 16;
  localparam int GAIN_BITS    = 16;
  localparam int GAIN_FRAC    = 15;
  localparam int TABLE_SIZE   = (1 << PHASE_BITS) + 1;
  localparam int PROD_COUNT   = 2 * CHANNELS;
  localparam int ACC_BITS     = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(PHASE_BITS + 1);
  localparam int MAC_CNT_BITS = $clog2(PROD_COUNT + 2);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;
  typedef logic [PHASE_BITS:0]           phase_t;
  typedef logic [LEN_BITS-1:0]           len_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic [DIV_CNT_BITS-1:0]       div_cnt_t;
  typedef logic [MAC_CNT_BITS-1:0]       mac_cnt_t;

  localparam gain_t  GAIN_ONE          = gain_t'(1 << GAIN_FRAC);
  localparam phase_t PHASE_MAX         = phase_t'(1 << PHASE_BITS);
  localparam len_t   FADE_LENGTH_RESET = len_t'(480);

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] Q62_ONE     = 64'h4000000000000000;

  typedef struct packed {
    logic    start_request;
    sample_t old_left;
    sample_t old_right;
    sample_t new_left;
    sample_t new_right;
  } frame_t;

  typedef struct packed {
    sample_t mixed_left;
    sample_t mixed_right;
    logic    fading;
    logic    fade_done;
  } mix_t;

  typedef logic [TABLE_SIZE-1:0][GAIN_BITS-1:0] gain_table_t;

  // (a*b) >> 62 for q62 operands
  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // restoring long division, elaboration only
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // taylor series in q62, odd selects sine
  function automatic logic [63:0] series_q62(logic [63:0] x, logic odd);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] n;
    int          k;
    pos  = '0;
    neg  = '0;
    term = odd ? x : Q62_ONE;
    n    = odd ? 64'd1 : 64'd0;
    for (k = 0; k < 16; k++) begin
      if ((k & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
      term = div_u64(q62_mul(q62_mul(term, x), x), (n + 64'd1) * (n + 64'd2));
      n    = n + 64'd2;
    end
    return (pos > neg) ? (pos - neg) : 64'd0;
  endfunction

  // new-path gain sin/(cos+sin), rounded half up, 15 fraction bits
  function automatic gain_table_t build_gain_table();
    gain_table_t tab;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] d;
    logic [63:0] g;
    int          hi;
    int          lo;
    int          p;
    tab = '0;
    for (hi = 0; hi <= (TABLE_SIZE >> 5); hi++) begin
      for (lo = 0; lo < 32; lo++) begin
        p = hi * 32 + lo;
        if (p < TABLE_SIZE) begin
          x = (HALF_PI_Q62 >> PHASE_BITS) * 64'(p);
          s = series_q62(x, 1'b1) >> 20;
          d = (series_q62(x, 1'b0) >> 20) + s;
          g = div_u64((s << 16) + d, d << 1);
          if (p == 0) begin
            g = '0;
          end
          if (p == (1 << PHASE_BITS)) begin
            g = 64'(GAIN_ONE);
          end
          if (g > 64'(GAIN_ONE)) begin
            g = 64'(GAIN_ONE);
          end
          tab[p] = g[GAIN_BITS-1:0];
        end
      end
    end
    return tab;
  endfunction

  localparam gain_table_t GAIN_TABLE = build_gain_table();

endpackage

`default_nettype wire

>>> sv/epcm_frame_if.sv
// input channel of the crossfade mixer: valid/ready plus one stereo frame
// depends on epcm_pkg
`default_nettype none

interface epcm_frame_if;
  import epcm_pkg::*;

  logic   valid;
  logic   ready;
  frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/epcm_mix_if.sv
// output channel of the crossfade mixer: valid/ready plus one mixed frame
// depends on epcm_pkg
`default_nettype none

interface epcm_mix_if;
  import epcm_pkg::*;

  logic valid;
  logic ready;
  mix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/epcm_phase_div.sv
// serial phase divider: floor(pos * 2^PHASE_BITS / (len-1)), clamped
// one quotient bit per cycle; depends on epcm_pkg
`default_nettype none

module epcm_phase_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  epcm_pkg::len_t  pos_i,
  input  epcm_pkg::len_t  len_i,
  output logic            done_o,
  output epcm_pkg::phase_t phase_o
);
  import epcm_pkg::*;

  logic                  busy_q;
  logic                  sat_q;
  div_cnt_t              cnt_q;
  len_t                  den_q;
  len_t                  rem_q;
  logic [PHASE_BITS-1:0] quo_q;

  len_t              den_d;
  logic              sat_d;
  logic [LEN_BITS:0] rem_shift;
  logic [LEN_BITS:0] rem_sub;
  logic              fits;

  assign den_d     = len_i - len_t'(1);
  assign sat_d     = (len_i <= len_t'(1)) || (pos_i >= den_d);
  assign rem_shift = {rem_q, 1'b0};
  assign fits      = rem_shift >= {1'b0, den_q};
  assign rem_sub   = rem_shift - {1'b0, den_q};

  assign done_o  = busy_q && (cnt_q == '0);
  assign phase_o = sat_q ? PHASE_MAX : {1'b0, quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      sat_q  <= sat_d;
      cnt_q  <= sat_d ? div_cnt_t'(0) : div_cnt_t'(PHASE_BITS);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - div_cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_d;
      rem_q <= pos_i;
      quo_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= fits ? rem_sub[LEN_BITS-1:0] : rem_shift[LEN_BITS-1:0];
      quo_q <= {quo_q[PHASE_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> sv/epcm_gain_rom.sv
// quarter-wave gain rom, registered read
// depends on epcm_pkg (table built there)
`default_nettype none

module epcm_gain_rom (
  input  logic             clk_i,
  input  epcm_pkg::phase_t phase_i,
  output epcm_pkg::gain_t  gain_o
);
  import epcm_pkg::*;

  gain_t gain_q;

  always_ff @(posedge clk_i) begin
    gain_q <= GAIN_TABLE[phase_i];
  end

  assign gain_o = gain_q;

endmodule

`default_nettype wire

>>> sv/epcm_mac.sv
// shared multiply-accumulate: one sample x gain product per cycle,
// then round and saturate per channel; depends on epcm_pkg
`default_nettype none

module epcm_mac (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  epcm_pkg::frame_t frame_i,
  input  epcm_pkg::gain_t  gain_new_i,
  output logic             done_o,
  output epcm_pkg::sample_t mixed_left_o,
  output epcm_pkg::sample_t mixed_right_o
);
  import epcm_pkg::*;

  localparam int RND_BITS = ACC_BITS - GAIN_FRAC;

  logic     busy_q;
  logic     done_q;
  mac_cnt_t cnt_q;
  acc_t     prod_q;
  acc_t     acc_l_q;
  acc_t     acc_r_q;

  gain_t   gain_old;
  gain_t   gain_sel;
  sample_t samp_sel;
  acc_t    prod_d;
  logic    to_right;

  function automatic sample_t round_sat(acc_t v);
    acc_t                 r;
    logic [RND_BITS-1:0]  y;
    sample_t              res;
    r = v + acc_t'(1 << (GAIN_FRAC - 1));
    y = r[ACC_BITS-1:GAIN_FRAC];
    if ((&y[RND_BITS-1:SAMPLE_BITS-1]) || !(|y[RND_BITS-1:SAMPLE_BITS-1])) begin
      res = y[SAMPLE_BITS-1:0];
    end else if (y[RND_BITS-1]) begin
      res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  assign gain_old = GAIN_ONE - gain_new_i;

  // product order: old left, new left, old right, new right
  always_comb begin
    case (cnt_q)
      mac_cnt_t'(0): begin
        samp_sel = frame_i.old_left;
        gain_sel = gain_old;
      end
      mac_cnt_t'(1): begin
        samp_sel = frame_i.new_left;
        gain_sel = gain_new_i;
      end
      mac_cnt_t'(2): begin
        samp_sel = frame_i.old_right;
        gain_sel = gain_old;
      end
      mac_cnt_t'(3): begin
        samp_sel = frame_i.new_right;
        gain_sel = gain_new_i;
      end
      default: begin
        samp_sel = '0;
        gain_sel = '0;
      end
    endcase
  end

  assign prod_d   = acc_t'(samp_sel) * acc_t'($signed({1'b0, gain_sel}));
  assign to_right = cnt_q >= mac_cnt_t'(3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == mac_cnt_t'(PROD_COUNT));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + mac_cnt_t'(1);
        if (cnt_q == mac_cnt_t'(PROD_COUNT)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < mac_cnt_t'(PROD_COUNT)) begin
        prod_q <= prod_d;
      end
      if (cnt_q != '0) begin
        if (to_right) begin
          acc_r_q <= acc_r_q + prod_q;
        end else begin
          acc_l_q <= acc_l_q + prod_q;
        end
      end
    end
  end

  assign done_o        = done_q;
  assign mixed_left_o  = round_sat(acc_l_q);
  assign mixed_right_o = (CHANNELS >= 2) ? round_sat(acc_r_q) : sample_t'(0);

endmodule

`default_nettype wire

>>> sv/equal_power_crossfade_mixer.sv
// equal-power crossfade mixer, top level: sequencer, fade state, output register
// depends on epcm_pkg, epcm_frame_if, epcm_mix_if, epcm_phase_div,
// epcm_gain_rom and epcm_mac
//
// usage
//   frame_i carries one stereo frame per beat: old and new path samples (q1.23)
//   and a start request. mix_o returns exactly one beat per input beat with the
//   blended samples, a fading flag and a fade_done flag. fade_done marks the
//   frame that completes the fade; the caller then swaps the two paths.
//   fade_length is written through cfg_wr_en_i / cfg_wr_data_i while idle.
// sequence
//   one frame is worked at a time and frame_i is not ready meanwhile. a
//   pass-through frame runs the mac, which works its four products on a single
//   shared multiplier; the sequencer then sees the mac finish and loads the
//   output register. a blended frame first runs the phase divider (no quotient
//   bits when the phase is at its end, otherwise PHASE_BITS = 10 bits, one
//   quotient bit per cycle) and one rom read.
// reset and stall
//   reset leaves no fade running, position 0 and fade_length 480. no clearing
//   pass is needed. a result waits in the output register while the receiver
//   stalls; the next frame is still taken and worked, and is held back only
//   when its own result is ready to be written.
`default_nettype none

module equal_power_crossfade_mixer (
  input  logic                clk_i,
  input  logic                rst_ni,
  epcm_frame_if.sink          frame_i,
  epcm_mix_if.source          mix_o,
  input  logic                cfg_wr_en_i,
  input  epcm_pkg::len_t      cfg_wr_data_i
);
  import epcm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_ROM  = 5'b00100,
    ST_MAC  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // fade state and config
  len_t   fade_length_q;
  logic   fade_active_q;
  len_t   fade_pos_q;

  // per-frame working registers
  frame_t frame_q;
  logic   blend_q;
  gain_t  gain_new_q;

  // output register
  logic   out_valid_q;
  mix_t   out_data_q;

  logic    in_fire;
  logic    start_blend;
  len_t    pos_eff;
  logic    div_start;
  logic    div_done;
  phase_t  phase;
  gain_t   rom_gain;
  logic    mac_start;
  logic    mac_done;
  sample_t mixed_left;
  sample_t mixed_right;
  logic    out_free;
  logic    out_wr;
  len_t    len_eff;
  len_t    pos_next;
  logic    fade_end;

  // input side: take a frame only when the sequencer is free
  assign frame_i.ready = (state_q == ST_IDLE);
  assign in_fire       = frame_i.valid && frame_i.ready;

  // a request only counts when no fade runs; a new fade starts at position 0
  assign start_blend = fade_active_q || frame_i.data.start_request;
  assign pos_eff     = fade_active_q ? fade_pos_q : len_t'(0);

  assign div_start = in_fire && start_blend;
  // pass-through frames go straight to the mac with unity old gain
  assign mac_start = (in_fire && !start_blend) || (state_q == ST_ROM);

  assign out_free = !out_valid_q || mix_o.ready;
  assign out_wr   = (state_q == ST_OUT) && out_free;

  // zero length behaves as a single-frame fade
  assign len_eff  = (fade_length_q == '0) ? len_t'(1) : fade_length_q;
  assign pos_next = fade_pos_q + len_t'(1);
  assign fade_end = blend_q && ((pos_next >= len_eff) || (pos_next == '0));

  epcm_phase_div u_phase_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .pos_i   (pos_eff),
    .len_i   (fade_length_q),
    .done_o  (div_done),
    .phase_o (phase)
  );

  epcm_gain_rom u_gain_rom (
    .clk_i   (clk_i),
    .phase_i (phase),
    .gain_o  (rom_gain)
  );

  epcm_mac u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (mac_start),
    .frame_i       (frame_q),
    .gain_new_i    (gain_new_q),
    .done_o        (mac_done),
    .mixed_left_o  (mixed_left),
    .mixed_right_o (mixed_right)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = start_blend ? ST_DIV : ST_MAC;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_ROM;
        end
      end
      ST_ROM: begin
        state_d = ST_MAC;
      end
      ST_MAC: begin
        if (mac_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_wr) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fade_length_q <= FADE_LENGTH_RESET;
      fade_active_q <= 1'b0;
      fade_pos_q    <= '0;
      blend_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        fade_length_q <= cfg_wr_data_i;
      end
      if (in_fire) begin
        blend_q <= start_blend;
      end
      // fade state: armed on accept, advanced when the blended result is written
      if (div_start) begin
        fade_active_q <= 1'b1;
        fade_pos_q    <= pos_eff;
      end else if (out_wr && blend_q) begin
        if (fade_end) begin
          fade_active_q <= 1'b0;
          fade_pos_q    <= '0;
        end else begin
          fade_pos_q <= pos_next;
        end
      end
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (mix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      frame_q <= frame_i.data;
    end
    if (in_fire && !start_blend) begin
      gain_new_q <= '0;
    end else if (state_q == ST_ROM) begin
      gain_new_q <= rom_gain;
    end
    if (out_wr) begin
      out_data_q.mixed_left  <= mixed_left;
      out_data_q.mixed_right <= mixed_right;
      out_data_q.fading      <= blend_q;
      out_data_q.fade_done   <= fade_end;
    end
  end

  assign mix_o.valid = out_valid_q;
  assign mix_o.data  = out_data_q;

  // checks

  a_done_within_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_o.valid && mix_o.data.fade_done |-> mix_o.data.fading)
    else $error("fade_done raised on a frame that was not blended");

  a_end_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_wr && fade_end |=> !fade_active_q && (fade_pos_q == '0))
    else $error("fade state not cleared after the completing frame");

  a_div_only_blending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> fade_active_q && blend_q)
    else $error("phase divider running outside a fade");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("phase divider finished while the sequencer was elsewhere");

  a_mac_done_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_MAC))
    else $error("mac finished while the sequencer was elsewhere");

endmodule

`default_nettype wire
